[rtl/core/rtphp_pkg.sv]
// ----------------------------------------------------------------------------
// rtphp_pkg
// Shared types and constants of the RTP header parser.
// ----------------------------------------------------------------------------
package rtphp_pkg;

	localparam int HEADER_LEN = 12;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SHORT   = 2'd1;
	localparam logic [1:0] ST_BAD_VER = 2'd2;

	// media class codes
	localparam logic [1:0] MC_VIDEO   = 2'd0;
	localparam logic [1:0] MC_PRIVATE = 2'd1;
	localparam logic [1:0] MC_AUDIO   = 2'd2;

	// payload types that select a media class
	localparam logic [6:0] PT_VIDEO_A = 7'h60;
	localparam logic [6:0] PT_VIDEO_B = 7'h1A;
	localparam logic [6:0] PT_PRIVATE = 7'h70;

	// configuration register indexes
	localparam logic [2:0] CFG_MIN_LEN   = 3'd0;
	localparam logic [2:0] CFG_ONE_PROF  = 3'd1;
	localparam logic [2:0] CFG_TWO_PROF  = 3'd2;
	localparam logic [2:0] CFG_TSEQ_ID   = 3'd3;
	localparam logic [2:0] CFG_MAX_PAD   = 3'd4;

	localparam int RES_W = 144;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_ZERO,
		PH_LEN,
		PH_DATA,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		FMT_NONE,
		FMT_ONE,
		FMT_TWO
	} fmt_t;

	typedef struct packed {
		logic [7:0]  min_packet_len;
		logic [15:0] one_byte_profile;
		logic [15:0] two_byte_profile;
		logic [7:0]  tseq_element_id;
		logic [7:0]  max_padding_len;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        marker;
		logic [6:0]  payload_type;
		logic [15:0] seq_no;
		logic [31:0] time_stamp;
		logic [31:0] ssrc_id;
		logic [1:0]  media_class;
		logic [15:0] payload_offset;
		logic [15:0] payload_len;
		logic        retransmit;
		logic        tseq_valid;
		logic [15:0] tseq_value;
	} res_t;

endpackage

[rtl/core/rtphp_core.sv]
// ----------------------------------------------------------------------------
// rtphp_core
// Per-byte packet state and the result logic taken at the last byte.
// ----------------------------------------------------------------------------
module rtphp_core
	import rtphp_pkg::*;
#(
	parameter int TAIL_LEN = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output res_t       res
);

	logic [15:0] cnt_q, cnt_n;
	logic [7:0]  hdr_q [HEADER_LEN];
	logic [7:0]  hdr_n [HEADER_LEN];
	logic [15:0] prof_q, prof_n;
	logic [17:0] ext_len_q, ext_len_n;
	logic [15:0] ext_off_q, ext_off_n;
	fmt_t        fmt_q, fmt_n;
	phase_t      phase_q, phase_n;
	logic [7:0]  skip_q, skip_n;
	logic [2:0]  due_q, due_n;
	logic [16:0] cap_q, cap_n;
	logic [7:0]  tail_q [TAIL_LEN];
	logic [7:0]  tail_n [TAIL_LEN];
	logic        done_q, done_n;
	logic        active_q, active_n;

	logic        xbit;
	logic [18:0] off_sum;
	phase_t      ph;
	logic [15:0] offset;
	logic [7:0]  pad;
	logic        retr;
	logic [17:0] diff;
	logic [6:0]  pt;

	always_comb begin
		cnt_n     = cnt_q;
		hdr_n     = hdr_q;
		prof_n    = prof_q;
		ext_len_n = ext_len_q;
		ext_off_n = ext_off_q;
		fmt_n     = fmt_q;
		phase_n   = phase_q;
		skip_n    = skip_q;
		due_n     = due_q;
		cap_n     = cap_q;
		done_n    = done_q;
		active_n  = active_q;
		xbit      = hdr_q[0][4];
		off_sum   = 19'd16 + {1'b0, ext_len_q[15:8], data_byte, 2'b00};
		ph        = phase_q;

		if (cnt_q < 16'(HEADER_LEN)) begin
			hdr_n[cnt_q[3:0]] = data_byte;
		end else if (cnt_q < 16'd16) begin
			if (xbit) begin
				case (cnt_q[1:0])
					2'd0: prof_n[15:8] = data_byte;
					2'd1: prof_n[7:0]  = data_byte;
					2'd2: ext_len_n    = {2'b00, data_byte, 8'h00};
					default: begin
						ext_len_n = {ext_len_q[15:8], data_byte, 2'b00};
						ext_off_n = (off_sum > 19'd65535) ? 16'hFFFF : off_sum[15:0];
						if (prof_q == cfg.one_byte_profile) fmt_n = FMT_ONE;
						else if (prof_q == cfg.two_byte_profile) fmt_n = FMT_TWO;
						else fmt_n = FMT_NONE;
						phase_n = PH_HDR;
						due_n   = 3'b000;
						if (ext_len_n == 18'd0) done_n = 1'b1;
						else active_n = 1'b1;
					end
				endcase
			end
		end else if (active_q) begin
			if (due_q[0]) cap_n = {1'b1, tail_q[0], data_byte};
			due_n = due_q >> 1;
			if (fmt_q != FMT_NONE) begin
				if (ph == PH_ZERO && data_byte != 8'h00) ph = PH_HDR;
				case (ph)
					PH_HDR: begin
						if (fmt_q == FMT_ONE) begin
							if (data_byte[7:4] == 4'hF) begin
								phase_n = PH_STOP;
							end else begin
								if ({4'h0, data_byte[7:4]} == cfg.tseq_element_id)
									due_n = due_n | 3'b010;
								skip_n  = {4'h0, data_byte[3:0]} + 8'd1;
								phase_n = PH_DATA;
							end
						end else begin
							if (data_byte == cfg.tseq_element_id) due_n = due_n | 3'b100;
							phase_n = PH_LEN;
						end
					end
					PH_LEN: begin
						skip_n  = data_byte;
						phase_n = (data_byte != 8'h00) ? PH_DATA : PH_ZERO;
					end
					PH_DATA: begin
						skip_n = skip_q - 8'd1;
						if (skip_q == 8'd1) phase_n = PH_ZERO;
					end
					default: begin
					end
				endcase
			end
			ext_len_n = ext_len_q - 18'd1;
			if (ext_len_q == 18'd1) begin
				active_n = 1'b0;
				done_n   = 1'b1;
			end
		end

		tail_n[0] = data_byte;
		for (int i = 1; i < TAIL_LEN; i++) tail_n[i] = tail_q[i - 1];
		if (cnt_q != 16'hFFFF) cnt_n = cnt_q + 16'd1;
	end

	// result at the last byte, built from the updated state
	always_comb begin
		res    = '0;
		pt     = hdr_n[1][6:0];
		offset = 16'(HEADER_LEN);
		pad    = 8'h00;
		retr   = 1'b0;
		if (hdr_n[0][4]) begin
			if (done_n) offset = (cnt_q == 16'd15) ? 16'd16 : ext_off_q;
			else if (cnt_n >= 16'd16) offset = cnt_n;
		end
		if (hdr_n[0][5] && data_byte != 8'h00 && data_byte <= cfg.max_padding_len) begin
			pad = data_byte;
			if (data_byte >= 8'(TAIL_LEN)) retr = tail_n[TAIL_LEN - 1][4];
		end
		diff = {2'b00, cnt_n} - {2'b00, offset} - {10'h000, pad};

		if (cnt_n < {8'h00, cfg.min_packet_len} || cnt_n < 16'(HEADER_LEN)) begin
			res.status = ST_SHORT;
		end else if (hdr_n[0][7:6] != 2'b10) begin
			res.status = ST_BAD_VER;
		end else begin
			res.status         = ST_OK;
			res.marker         = hdr_n[1][7];
			res.payload_type   = pt;
			res.seq_no         = {hdr_n[2], hdr_n[3]};
			res.time_stamp     = {hdr_n[4], hdr_n[5], hdr_n[6], hdr_n[7]};
			res.ssrc_id        = {hdr_n[8], hdr_n[9], hdr_n[10], hdr_n[11]};
			res.media_class    = (pt == PT_VIDEO_A || pt == PT_VIDEO_B) ? MC_VIDEO :
				(pt == PT_PRIVATE ? MC_PRIVATE : MC_AUDIO);
			res.payload_offset = offset;
			res.payload_len    = diff[17] ? 16'h0000 : diff[15:0];
			res.retransmit     = retr;
			if (hdr_n[0][4] && done_n && cap_n[16]) begin
				res.tseq_valid = 1'b1;
				res.tseq_value = cap_n[15:0];
			end
		end
	end

	// header, profile, extension length, offset and skip words need no reset: written before use
	always_ff @(posedge clk) begin
		if (step) begin
			hdr_q     <= hdr_n;
			prof_q    <= prof_n;
			ext_len_q <= ext_len_n;
			ext_off_q <= ext_off_n;
			skip_q    <= skip_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			fmt_q    <= FMT_NONE;
			phase_q  <= PH_HDR;
			due_q    <= '0;
			cap_q    <= '0;
			done_q   <= 1'b0;
			active_q <= 1'b0;
			for (int i = 0; i < TAIL_LEN; i++) tail_q[i] <= '0;
		end else if (step) begin
			if (last_byte) begin
				// drop the counter, phase, flag, capture and tail state after the result
				cnt_q    <= '0;
				fmt_q    <= FMT_NONE;
				phase_q  <= PH_HDR;
				due_q    <= '0;
				cap_q    <= '0;
				done_q   <= 1'b0;
				active_q <= 1'b0;
				for (int i = 0; i < TAIL_LEN; i++) tail_q[i] <= '0;
			end else begin
				cnt_q    <= cnt_n;
				fmt_q    <= fmt_n;
				phase_q  <= phase_n;
				due_q    <= due_n;
				cap_q    <= cap_n;
				done_q   <= done_n;
				active_q <= active_n;
				tail_q   <= tail_n;
			end
		end
	end

endmodule

[rtl/core/rtp_header_parser_top.sv]
// ----------------------------------------------------------------------------
// rtp_header_parser_top
// RTP fixed header and header extension parser, one packet byte per word.
// ----------------------------------------------------------------------------
//  channel  direction  word                     accepted when
//  s_axis   in         packet byte, tlast       s_axis_tvalid & s_axis_tready
//  m_axis   out        one result per packet    m_axis_tvalid & m_axis_tready
//  cfg      in         register index, data     cfg_valid & cfg_ready
//
//  One byte per cycle: a byte goes to an input register, is folded into the
//  packet state in the next cycle, and the last byte loads the result register.
//  A packet's result is presented from the result register once its last byte leaves the input register.
//  Reset sets the configuration registers to their defaults and clears state.
//  Input stalls only while a last byte waits on a full, stalled result register.
// ----------------------------------------------------------------------------
module rtp_header_parser_top
	import rtphp_pkg::*;
#(
	parameter int TAIL_LEN = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // data_byte
	input  logic               s_axis_tlast,   // last_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// status, marker, payload_type, seq_no, time_stamp, ssrc_id, media_class,
	// payload_offset, payload_len, retransmit, tseq_valid, tseq_value, zero fill
	output logic [RES_W-1:0]   m_axis_tdata,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	cfg_t       cfg_q;
	logic       s1_valid_q;
	logic [7:0] s1_byte_q;
	logic       s1_last_q;
	logic       advance;
	logic       step;
	res_t       res;
	res_t       out_q;
	logic       out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_packet_len   <= 8'd12;
			cfg_q.one_byte_profile <= 16'hBEDE;
			cfg_q.two_byte_profile <= 16'h1000;
			cfg_q.tseq_element_id  <= 8'd5;
			cfg_q.max_padding_len  <= 8'd255;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_LEN:  cfg_q.min_packet_len   <= cfg_data[7:0];
				CFG_ONE_PROF: cfg_q.one_byte_profile <= cfg_data;
				CFG_TWO_PROF: cfg_q.two_byte_profile <= cfg_data;
				CFG_TSEQ_ID:  cfg_q.tseq_element_id  <= cfg_data[7:0];
				CFG_MAX_PAD:  cfg_q.max_padding_len  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// hold a last byte while the result register cannot take its result
	assign advance       = !(s1_valid_q && s1_last_q && out_valid_q && !m_axis_tready);
	assign s_axis_tready = advance;
	assign step          = s1_valid_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s1_byte_q <= s_axis_tdata;
			s1_last_q <= s_axis_tlast;
		end
	end

	rtphp_core #(
		.TAIL_LEN (TAIL_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (step),
		.data_byte (s1_byte_q),
		.last_byte (s1_last_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && s1_last_q) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && s1_last_q) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.tseq_value, out_q.tseq_valid, out_q.retransmit,
		out_q.payload_len, out_q.payload_offset, out_q.media_class, out_q.ssrc_id,
		out_q.time_stamp, out_q.seq_no, out_q.payload_type, out_q.marker, out_q.status};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> s1_valid_q && s1_last_q && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a blocked result");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.status != ST_OK |->
		out_q.payload_offset == 16'h0000 && out_q.seq_no == 16'h0000 &&
		out_q.tseq_valid == 1'b0 && out_q.payload_len == 16'h0000)
		else $error("failed packet carries field data");

	a_offset_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.status == ST_OK |-> out_q.payload_offset >= 16'd12)
		else $error("payload offset inside fixed header");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_q.status != 2'd3 && out_q.media_class != 2'd3)
		else $error("undefined status or media class code");

endmodule
